// ===== design/frws_pkg.sv =====
// frws_pkg: shared types, constants and the control store of the frame rate
// window statistics core. Depends on nothing; imported by
// frame_rate_window_stats_core.
package frws_pkg;

	// Field widths and limits
	localparam int unsigned MS_W       = 16;
	localparam int unsigned FPS_W      = 10;
	localparam int unsigned OUT_DATA_W = 64;
	localparam int unsigned MS_PER_SEC = 1000;
	localparam int unsigned MIN_MS     = 1;
	localparam int unsigned MAX_MS     = 1000;

	// Micro-operation driven into the datapath by one control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_READ,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_DIV_STORE,
		OP_EMIT
	} op_t;

	// Which quotient a division step group works on
	typedef enum logic [1:0] {
		SEL_AVG,
		SEL_BEST,
		SEL_WORST,
		SEL_LATEST
	} sel_t;

	// Condition that keeps the step counter on the current step
	typedef enum logic [2:0] {
		HOLD_NONE,
		HOLD_INPUT,
		HOLD_WALK,
		HOLD_DIV,
		HOLD_OUTPUT
	} hold_t;

	localparam int unsigned UC_W = 4;

	typedef logic [UC_W-1:0] step_t;

	typedef struct packed {
		op_t   op;
		sel_t  sel;
		hold_t hold;
		logic  jmp;
		step_t target;
	} ucode_t;

	// Program step addresses
	localparam step_t ST_IDLE     = 4'd0;
	localparam step_t ST_WALK     = 4'd1;
	localparam step_t ST_DRAIN    = 4'd2;
	localparam step_t ST_AVG_LD   = 4'd3;
	localparam step_t ST_AVG_IT   = 4'd4;
	localparam step_t ST_AVG_ST   = 4'd5;
	localparam step_t ST_BEST_LD  = 4'd6;
	localparam step_t ST_BEST_IT  = 4'd7;
	localparam step_t ST_BEST_ST  = 4'd8;
	localparam step_t ST_WORST_LD = 4'd9;
	localparam step_t ST_WORST_IT = 4'd10;
	localparam step_t ST_WORST_ST = 4'd11;
	localparam step_t ST_LAT_LD   = 4'd12;
	localparam step_t ST_LAT_IT   = 4'd13;
	localparam step_t ST_LAT_ST   = 4'd14;
	localparam step_t ST_EMIT     = 4'd15;

	// Control store: one word per step
	function automatic ucode_t ucode_fetch(input step_t pc);
		ucode_t cw;
		unique case (pc)
			ST_IDLE:     cw = '{OP_ACCEPT,    SEL_AVG,    HOLD_INPUT,  1'b0, ST_IDLE};
			ST_WALK:     cw = '{OP_READ,      SEL_AVG,    HOLD_WALK,   1'b0, ST_IDLE};
			ST_DRAIN:    cw = '{OP_NOP,       SEL_AVG,    HOLD_NONE,   1'b0, ST_IDLE};
			ST_AVG_LD:   cw = '{OP_DIV_LOAD,  SEL_AVG,    HOLD_NONE,   1'b0, ST_IDLE};
			ST_AVG_IT:   cw = '{OP_DIV_STEP,  SEL_AVG,    HOLD_DIV,    1'b0, ST_IDLE};
			ST_AVG_ST:   cw = '{OP_DIV_STORE, SEL_AVG,    HOLD_NONE,   1'b0, ST_IDLE};
			ST_BEST_LD:  cw = '{OP_DIV_LOAD,  SEL_BEST,   HOLD_NONE,   1'b0, ST_IDLE};
			ST_BEST_IT:  cw = '{OP_DIV_STEP,  SEL_BEST,   HOLD_DIV,    1'b0, ST_IDLE};
			ST_BEST_ST:  cw = '{OP_DIV_STORE, SEL_BEST,   HOLD_NONE,   1'b0, ST_IDLE};
			ST_WORST_LD: cw = '{OP_DIV_LOAD,  SEL_WORST,  HOLD_NONE,   1'b0, ST_IDLE};
			ST_WORST_IT: cw = '{OP_DIV_STEP,  SEL_WORST,  HOLD_DIV,    1'b0, ST_IDLE};
			ST_WORST_ST: cw = '{OP_DIV_STORE, SEL_WORST,  HOLD_NONE,   1'b0, ST_IDLE};
			ST_LAT_LD:   cw = '{OP_DIV_LOAD,  SEL_LATEST, HOLD_NONE,   1'b0, ST_IDLE};
			ST_LAT_IT:   cw = '{OP_DIV_STEP,  SEL_LATEST, HOLD_DIV,    1'b0, ST_IDLE};
			ST_LAT_ST:   cw = '{OP_DIV_STORE, SEL_LATEST, HOLD_NONE,   1'b0, ST_IDLE};
			ST_EMIT:     cw = '{OP_EMIT,      SEL_AVG,    HOLD_OUTPUT, 1'b1, ST_IDLE};
		endcase
		return cw;
	endfunction

endpackage

// ===== design/frame_rate_window_stats_core.sv =====
// frame_rate_window_stats_core: moving-window frame rate statistics.
// Microcoded sequencer, window memory, serial divider. Depends on frws_pkg.
//
// Usage:
//  - Slave stream (s_axis_*): one transaction per rendered frame, tdata[15:0]
//    is the frame duration in ms. It is clamped to 1..1000 and written into a
//    ring window of the last HISTORY_DEPTH frames.
//  - Master stream (m_axis_*): one transaction per input, carrying average,
//    best and worst rate, both margins and the rate of the newest frame.
//  - One input is in flight at a time, and each is taken in an accept step
//    of its own. The processing time is set by the window walk (one memory
//    read per cycle) and four quotients from one shared radix-2 divider
//    (one quotient bit per cycle).
//  - The result sits in an output register; the next input is taken while it
//    waits. If the receiver stalls, the sequencer holds at its last step
//    until the register frees up, and s_axis_tready stays low meanwhile.
//  - Reset: window entries read as 1 (per-entry valid bits cleared), write
//    slot back to 0, no result pending. Ready as soon as reset is released.
module frame_rate_window_stats_core
	import frws_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 60
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Slave stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [MS_W-1:0]       s_axis_tdata,   // [15:0] frame_millis
	// Master stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // [9:0] average_fps, [19:10] best_fps,
	                                              // [29:20] worst_fps, [39:30] best_margin,
	                                              // [49:40] worst_margin, [59:50] latest_fps
);

	localparam int unsigned IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned NUM_AVG = HISTORY_DEPTH * MS_PER_SEC;
	localparam int unsigned SUM_W   = $clog2(NUM_AVG + 1);
	localparam int unsigned CNT_W   = $clog2(SUM_W + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

	// Sequencer
	step_t  pc_q, pc_d;
	ucode_t cw;
	logic   hold;

	// Window storage and walk
	logic [FPS_W-1:0]         mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]         slot_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic [FPS_W-1:0]         rd_data_s1;
	logic                     rd_vbit_s1;
	logic                     rd_vld_s1;
	logic [FPS_W-1:0]         entry;

	// Statistics
	logic [FPS_W-1:0] ms_clamped;
	logic [FPS_W-1:0] ms_q;
	logic [SUM_W-1:0] sum_q;
	logic [FPS_W-1:0] lo_q, hi_q;

	// Divider
	logic [SUM_W-1:0] rem_q, quo_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W:0]   rem_sh, diff;
	logic             ge;

	// Results
	logic [FPS_W-1:0] avg_q, best_q, worst_q, latest_q;
	logic [FPS_W-1:0] best_margin, worst_margin;
	logic             m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic in_fire, emit_fire;

	// Control word fetch and handshake strobes
	assign cw            = ucode_fetch(pc_q);
	assign s_axis_tready = (cw.op == OP_ACCEPT);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign emit_fire     = (cw.op == OP_EMIT) && !hold;

	// Hold condition of the current step
	always_comb begin
		unique case (cw.hold)
			HOLD_NONE:   hold = 1'b0;
			HOLD_INPUT:  hold = !s_axis_tvalid;
			HOLD_WALK:   hold = (rd_idx_q != IDX_LAST);
			HOLD_DIV:    hold = (cnt_q != CNT_W'(1));
			HOLD_OUTPUT: hold = m_tvalid_q && !m_axis_tready;
			default:     hold = 1'b0;
		endcase
	end

	// Next step
	always_comb begin
		if (hold) begin
			pc_d = pc_q;
		end else if (cw.jmp) begin
			pc_d = cw.target;
		end else begin
			pc_d = pc_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Clamp the incoming duration to 1..1000
	always_comb begin
		if (s_axis_tdata < MS_W'(MIN_MS)) begin
			ms_clamped = FPS_W'(MIN_MS);
		end else if (s_axis_tdata > MS_W'(MAX_MS)) begin
			ms_clamped = FPS_W'(MAX_MS);
		end else begin
			ms_clamped = s_axis_tdata[FPS_W-1:0];
		end
	end

	// Window memory: write on accept, one read per walk step
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mem[slot_q] <= ms_clamped;
		end
		if (cw.op == OP_READ) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	// Valid bits, write slot, walk index and read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			slot_q     <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_vbit_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (cw.op == OP_READ);
			if (in_fire) begin
				valid_q[slot_q] <= 1'b1;
				slot_q          <= (slot_q == IDX_LAST) ? '0 : slot_q + IDX_W'(1);
				rd_idx_q        <= '0;
			end else if (cw.op == OP_READ) begin
				rd_vbit_s1 <= valid_q[rd_idx_q];
				rd_idx_q   <= (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + IDX_W'(1);
			end
		end
	end

	// Never-written entries read as one
	assign entry = rd_vbit_s1 ? rd_data_s1 : FPS_W'(MIN_MS);

	// Sum, minimum and maximum over the window
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ms_q  <= ms_clamped;
			sum_q <= '0;
			lo_q  <= FPS_W'(MAX_MS);
			hi_q  <= FPS_W'(MIN_MS);
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(entry);
			if (entry < lo_q) begin
				lo_q <= entry;
			end
			if (entry > hi_q) begin
				hi_q <= entry;
			end
		end
	end

	// Restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = !diff[SUM_W];

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_DIV_LOAD: begin
				rem_q <= '0;
				cnt_q <= CNT_W'(SUM_W);
				quo_q <= (cw.sel == SEL_AVG) ? SUM_W'(NUM_AVG) : SUM_W'(MS_PER_SEC);
				unique case (cw.sel)
					SEL_AVG:    dvs_q <= sum_q;
					SEL_BEST:   dvs_q <= SUM_W'(lo_q);
					SEL_WORST:  dvs_q <= SUM_W'(hi_q);
					SEL_LATEST: dvs_q <= SUM_W'(ms_q);
					default:    dvs_q <= sum_q;
				endcase
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Quotient capture
	always_ff @(posedge clk) begin
		if (cw.op == OP_DIV_STORE) begin
			unique case (cw.sel)
				SEL_AVG:    avg_q    <= quo_q[FPS_W-1:0];
				SEL_BEST:   best_q   <= quo_q[FPS_W-1:0];
				SEL_WORST:  worst_q  <= quo_q[FPS_W-1:0];
				SEL_LATEST: latest_q <= quo_q[FPS_W-1:0];
				default:    avg_q    <= quo_q[FPS_W-1:0];
			endcase
		end
	end

	// Margins from the average, floored at zero
	assign best_margin  = (best_q >= avg_q) ? best_q - avg_q : '0;
	assign worst_margin = (avg_q >= worst_q) ? avg_q - worst_q : '0;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= {(OUT_DATA_W - 6 * FPS_W)'(0), latest_q, worst_margin, best_margin,
			              worst_q, best_q, avg_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// Checks
	a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == OP_DIV_STORE) |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor at store");

	a_window_stats_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == OP_DIV_LOAD && cw.sel == SEL_AVG) |->
		(sum_q >= SUM_W'(HISTORY_DEPTH) && lo_q <= hi_q && lo_q != '0))
		else $error("window sum or extremes out of range after walk");

	a_rates_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[19:10] >= m_axis_tdata[9:0] &&
		                   m_axis_tdata[9:0] >= m_axis_tdata[29:20]))
		else $error("best, average and worst rates out of order");

	a_output_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !emit_fire) |=> !m_axis_tvalid)
		else $error("result repeated after its transaction");

endmodule
